/* rtl/core/rrid_pkg.sv */
// Shared constants and types for the round-robin interrupt distributor.
package rrid_pkg;

   // Number of interrupt lines and CPUs the router serves
   localparam int LINE_COUNT = 16;
   localparam int CPU_COUNT  = 4;

   // CPUs that exist, limited to one affinity nibble
   localparam logic [3:0] CPU_EXIST_MASK =
      (CPU_COUNT >= 4) ? 4'hF : 4'((1 << CPU_COUNT) - 1);

   // Line two is never serviced
   localparam logic [3:0]  SKIP_LINE = 4'd2;

   // Pointer value meaning "before the first CPU"
   localparam logic [2:0]  PTR_RESET = 3'b111;

   // Register reset values
   localparam logic [15:0] LOCAL_MASK_RESET  = 16'h1187;
   localparam logic [63:0] AFFINITY_RESET    = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [3:0]  ACTIVE_CPUS_RESET = 4'h1;

   // Configuration register indexes
   localparam logic [1:0] CSR_LOCAL_MASK  = 2'd0;
   localparam logic [1:0] CSR_AFFINITY    = 2'd1;
   localparam logic [1:0] CSR_ACTIVE_CPUS = 2'd2;

   // Fields of one routing result
   typedef struct packed {
      logic [3:0] line_number;
      logic [1:0] target_cpu;
      logic       send_ipi;
      logic       nothing_pending;
      logic       last;
   } result_type;

endpackage

/* rtl/core/rrid_pick.sv */
// Round-robin CPU picker: next allowed CPU after the previous pick, wrapping.
module rrid_pick (
   input  logic [2:0] prev_cpu,
   input  logic [3:0] allowed,
   output logic [1:0] cpu
);

   logic [1:0] start;
   logic [3:0] upper;

   // Return the index of the lowest set bit
   function automatic logic [1:0] lowest_bit(input logic [3:0] bits);
      logic [1:0] idx;
      idx = 2'd0;
      for (int i = 3; i >= 0; i--) begin
         if (bits[i]) idx = 2'(i);
      end
      return idx;
   endfunction

   // Start past the previous pick; an out-of-range pointer starts at CPU 0
   assign start = (prev_cpu >= 3'd3) ? 2'd0 : 2'(prev_cpu + 3'd1);
   assign upper = allowed & (4'hF << start);

   // Take the first allowed CPU at or above start, else wrap to the lowest
   always_comb begin
      if (upper != 4'h0) begin
         cpu = lowest_bit(upper);
      end else begin
         cpu = lowest_bit(allowed);
      end
   end

endmodule

/* rtl/core/round_robin_interrupt_distributor.sv */
// Top level: scans a pending vector line by line and routes each pending interrupt but SKIP_LINE.
//
//   channel  direction  handshake              payload
//   req      in         req_tvalid/req_tready  tdata: pending_vector
//   rsp      out        rsp_tvalid/rsp_tready  tdata: line, cpu, ipi; tuser; tlast
//   csr      in         csr_we                 csr_index, csr_wdata
//
// The sequencer visits one line per cycle, from line 0 up to the highest pending
// line, and holds on a pending line while the result register is stalled by
// rsp_tready. A new vector is taken once the last result has been loaded into
// the output register.
// Reset is synchronous; it restores the state and configuration registers and sets every line's
// round-robin pointer to "before the first CPU".
module round_robin_interrupt_distributor (
   input  logic        clock,
   input  logic        reset,
   // pending_vector [15:0]
   input  logic [15:0] req_tdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // line_number [3:0], target_cpu [5:4], send_ipi [6], zero [7]
   output logic [7:0]  rsp_tdata,
   // nothing_pending [0]
   output logic        rsp_tuser,
   output logic        rsp_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_SCAN
   } state_type;

   state_type          state_ff, state_in;
   logic [15:0]        rem_ff, rem_in;
   logic [3:0]         line_ff, line_in;
   logic               none_ff, none_in;
   logic [2:0]         ptr_ff [rrid_pkg::LINE_COUNT];
   logic               ptr_we;
   logic [1:0]         ptr_wdata;
   logic [15:0]        local_mask_ff;
   logic [63:0]        affinity_ff;
   logic [3:0]         active_ff;
   rrid_pkg::result_type res_ff, res_in;
   logic               valid_ff, valid_in;

   logic               slot_free;
   logic [15:0]        rem_clr;
   logic [3:0]         allowed;
   logic [1:0]         picked;
   logic               req_beat;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_beat   = req_tvalid && req_tready;
   assign slot_free  = !valid_ff || rsp_tready;

   // Allowed CPUs for the line under scan
   assign allowed = affinity_ff[{line_ff, 2'b00} +: 4] & active_ff & rrid_pkg::CPU_EXIST_MASK;
   assign rem_clr = rem_ff & ~(16'h0001 << line_ff);

   rrid_pick u_pick (
      .prev_cpu (ptr_ff[line_ff]),
      .allowed  (allowed),
      .cpu      (picked)
   );

   // Sequencer: step through lines, emit one beat per pending line, or one nothing_pending beat if none
   always_comb begin
      state_in  = state_ff;
      rem_in    = rem_ff;
      line_in   = line_ff;
      none_in   = none_ff;
      res_in    = res_ff;
      valid_in  = valid_ff && !rsp_tready;
      ptr_we    = 1'b0;
      ptr_wdata = picked;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               rem_in   = req_tdata & ~(16'h0001 << rrid_pkg::SKIP_LINE);
               none_in  = (rem_in == 16'h0000);
               line_in  = 4'd0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (none_ff) begin
               if (slot_free) begin
                  res_in          = '0;
                  res_in.nothing_pending = 1'b1;
                  res_in.last     = 1'b1;
                  valid_in        = 1'b1;
                  state_in        = ST_IDLE;
               end
            end else if (!rem_ff[line_ff]) begin
               line_in = line_ff + 4'd1;
            end else if (slot_free) begin
               res_in.line_number     = line_ff;
               res_in.nothing_pending = 1'b0;
               res_in.last            = (rem_clr == 16'h0000);
               if (!local_mask_ff[line_ff] && allowed != 4'h0) begin
                  ptr_we             = 1'b1;
                  res_in.target_cpu  = picked;
                  res_in.send_ipi    = (picked != 2'd0);
               end else begin
                  res_in.target_cpu  = 2'd0;
                  res_in.send_ipi    = 1'b0;
               end
               valid_in = 1'b1;
               rem_in   = rem_clr;
               line_in  = line_ff + 4'd1;
               if (rem_clr == 16'h0000) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Hold state, pointers, registers and the output beat
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         valid_ff      <= 1'b0;
         none_ff       <= 1'b0;
         line_ff       <= 4'd0;
         rem_ff        <= 16'h0000;
         local_mask_ff <= rrid_pkg::LOCAL_MASK_RESET;
         affinity_ff   <= rrid_pkg::AFFINITY_RESET;
         active_ff     <= rrid_pkg::ACTIVE_CPUS_RESET;
         for (int i = 0; i < rrid_pkg::LINE_COUNT; i++) begin
            ptr_ff[i] <= rrid_pkg::PTR_RESET;
         end
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         none_ff  <= none_in;
         line_ff  <= line_in;
         rem_ff   <= rem_in;
         if (ptr_we) ptr_ff[line_ff] <= {1'b0, ptr_wdata};
         if (csr_we) begin
            unique case (csr_index)
               rrid_pkg::CSR_LOCAL_MASK:  local_mask_ff <= csr_wdata[15:0];
               rrid_pkg::CSR_AFFINITY:    affinity_ff   <= csr_wdata;
               rrid_pkg::CSR_ACTIVE_CPUS: active_ff     <= csr_wdata[3:0];
               default: ;
            endcase
         end
      end
      res_ff <= res_in;
   end

   // Pack the result beat
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {1'b0, res_ff.send_ipi, res_ff.target_cpu, res_ff.line_number};
   assign rsp_tuser  = res_ff.nothing_pending;
   assign rsp_tlast  = res_ff.last;

endmodule
